FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the block's modules.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HSCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HSCD_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define HSCD_ASSERT(lbl, prop, msg)
`define HSCD_NEVER(lbl, expr, msg)
`endif
`endif

FILE: rtl/core/hscd_pkg.sv
// ----------------------------------------------------------------------------
// hscd_pkg
// Shared constants and controller/datapath interface types of the hue
// spread color cast detector.
// ----------------------------------------------------------------------------
package hscd_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int HUE_W      = 16;
	localparam int LVL_W      = 8;
	localparam int THR_W      = 31;
	localparam int ACC_W      = 47;
	localparam int TOT_W      = 32;
	localparam int DIV_W      = 48;
	localparam int DIVR_W     = CNT_W;
	localparam int DCNT_W     = $clog2(DIV_W);
	localparam int SQ_W       = 2 * HUE_W;

	localparam logic [THR_W-1:0] THR_RESET = 31'd25769803;

	typedef struct packed {
		logic load;         // capture the accepted pixel
		logic commit;       // store hue, add to total, bump count
		logic hue_zero;     // committed hue is zero (grey pixel)
		logic start_hue;    // launch hue divide
		logic start_mean;   // launch mean divide, clear spread sum
		logic load_mean;    // latch mean, reset walk index
		logic walk_issue;   // read next stored hue
		logic start_spread; // launch spread divide
		logic emit;         // load result register, clear frame state
	} cmd_t;

	typedef struct packed {
		logic grey;
		logic full;
		logic frame_end;
		logic div_done;
		logic walk_last;
		logic pipe_busy;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/core/hscd_ram.sv
// ----------------------------------------------------------------------------
// hscd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hscd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/hscd_div.sv
// ----------------------------------------------------------------------------
// hscd_div
// Restoring radix-2 divider, one quotient bit per cycle, shared by the hue,
// mean and spread divides.
// ----------------------------------------------------------------------------
module hscd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [hscd_pkg::DIV_W-1:0] dividend,
	input  logic [hscd_pkg::DIVR_W-1:0] divisor,
	output logic                       done,
	output logic [hscd_pkg::DIV_W-1:0] quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [hscd_pkg::DCNT_W-1:0]   cnt_q;
	logic [hscd_pkg::DIVR_W-1:0]   rem_q;
	logic [hscd_pkg::DIVR_W-1:0]   dvs_q;
	logic [hscd_pkg::DIV_W-1:0]    quo_q;
	logic [hscd_pkg::DIVR_W:0]     rem_sh;
	logic [hscd_pkg::DIVR_W:0]     rem_sub;
	logic                          fits;

	assign rem_sh  = {rem_q, quo_q[hscd_pkg::DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign fits    = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == hscd_pkg::DCNT_W'(hscd_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[hscd_pkg::DIVR_W-1:0] : rem_sh[hscd_pkg::DIVR_W-1:0];
			quo_q <= {quo_q[hscd_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/hscd_datapath.sv
// ----------------------------------------------------------------------------
// hscd_datapath
// Pixel hue math, hue store, frame accumulators, deviation walk and result
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hscd_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  hscd_pkg::cmd_t               cmd,
	output hscd_pkg::status_t            status,
	input  logic [hscd_pkg::LVL_W-1:0]   red_level,
	input  logic [hscd_pkg::LVL_W-1:0]   green_level,
	input  logic [hscd_pkg::LVL_W-1:0]   blue_level,
	input  logic                         frame_end,
	input  logic                         cfg_wr_en,
	input  logic [hscd_pkg::THR_W-1:0]   cfg_wr_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hscd_pkg::THR_W-1:0]   hue_spread,
	output logic                         cast_present,
	output logic [hscd_pkg::CNT_W-1:0]   pixel_total
);

	logic [hscd_pkg::LVL_W-1:0]  r_q, g_q, b_q;
	logic                        fe_q;
	logic [hscd_pkg::THR_W-1:0]  thr_q;
	logic [hscd_pkg::TOT_W-1:0]  hue_total_q;
	logic [hscd_pkg::CNT_W-1:0]  count_q;
	logic [hscd_pkg::ACC_W-1:0]  acc_q;
	logic [hscd_pkg::HUE_W-1:0]  mean_q;
	logic [hscd_pkg::CNT_W-1:0]  idx_q;
	logic                        v_s1, v_s2;
	logic [hscd_pkg::SQ_W-1:0]   term_s2;
	logic                        out_valid_q;
	logic [hscd_pkg::THR_W-1:0]  spread_q;
	logic                        cast_q;
	logic [hscd_pkg::CNT_W-1:0]  total_q;

	logic [hscd_pkg::LVL_W-1:0]  mx, mn, dlt;
	logic signed [11:0]          n_raw, n_fix;
	logic [26:0]                 hue_num;
	logic [hscd_pkg::HUE_W-1:0]  hue_val;
	logic                        div_start;
	logic [hscd_pkg::DIV_W-1:0]  div_dvd;
	logic [hscd_pkg::DIVR_W-1:0] div_dvs;
	logic                        div_done;
	logic [hscd_pkg::DIV_W-1:0]  div_quo;
	logic [hscd_pkg::HUE_W-1:0]  rd_hue;
	logic [hscd_pkg::HUE_W-1:0]  dev_a;
	logic [hscd_pkg::HUE_W:0]    dev_b;
	logic [hscd_pkg::HUE_W-1:0]  dev_c;
	logic                        out_xfer;

	// Hue of the captured pixel; ties go red, then blue, then green.
	always_comb begin
		mx = r_q;
		mn = r_q;
		if (b_q > mx) mx = b_q;
		if (g_q > mx) mx = g_q;
		if (b_q < mn) mn = b_q;
		if (g_q < mn) mn = g_q;
		dlt = mx - mn;
		if (mx == r_q) begin
			n_raw = $signed({4'b0, g_q}) - $signed({4'b0, b_q});
		end else if (mx == b_q) begin
			n_raw = $signed({2'b0, dlt, 2'b0}) + $signed({4'b0, r_q})
				- $signed({4'b0, g_q});
		end else begin
			n_raw = $signed({3'b0, dlt, 1'b0}) + $signed({4'b0, b_q})
				- $signed({4'b0, r_q});
		end
		n_fix = n_raw;
		if (n_raw < 0) begin
			n_fix = n_raw + $signed(12'(6 * dlt));
		end
		hue_num = {n_fix[10:0], 16'b0} + 27'(3 * dlt);
	end

	always_comb begin
		div_start = cmd.start_hue | cmd.start_mean | cmd.start_spread;
		div_dvd   = hscd_pkg::DIV_W'(hue_num);
		div_dvs   = hscd_pkg::DIVR_W'(6 * dlt);
		if (cmd.start_mean) begin
			div_dvd = hscd_pkg::DIV_W'(hue_total_q) + hscd_pkg::DIV_W'(count_q >> 1);
			div_dvs = count_q;
		end else if (cmd.start_spread) begin
			div_dvd = hscd_pkg::DIV_W'(acc_q) + hscd_pkg::DIV_W'(count_q >> 1);
			div_dvs = count_q;
		end
	end

	hscd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign hue_val = cmd.hue_zero ? '0 : div_quo[hscd_pkg::HUE_W-1:0];

	hscd_ram #(
		.WIDTH (hscd_pkg::HUE_W),
		.DEPTH (hscd_pkg::MAX_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (count_q[hscd_pkg::ADDR_W-1:0]),
		.wdata (hue_val),
		.raddr (idx_q[hscd_pkg::ADDR_W-1:0]),
		.rdata (rd_hue)
	);

	// Circular distance to the mean, squared.
	always_comb begin
		dev_a = (mean_q >= rd_hue) ? mean_q - rd_hue : rd_hue - mean_q;
		dev_b = (hscd_pkg::HUE_W+1)'(1 << hscd_pkg::HUE_W) - {1'b0, dev_a};
		dev_c = ({1'b0, dev_a} < dev_b) ? dev_a : dev_b[hscd_pkg::HUE_W-1:0];
	end

	assign out_xfer = out_valid_q & out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q <= red_level;
			g_q <= green_level;
			b_q <= blue_level;
		end
		if (cmd.load_mean) begin
			mean_q <= div_quo[hscd_pkg::HUE_W-1:0];
		end
		term_s2 <= dev_c * dev_c;
		if (cmd.emit) begin
			spread_q <= div_quo[hscd_pkg::THR_W-1:0];
			cast_q   <= div_quo <= hscd_pkg::DIV_W'(thr_q);
			total_q  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q        <= 1'b0;
			thr_q       <= hscd_pkg::THR_RESET;
			hue_total_q <= '0;
			count_q     <= '0;
			acc_q       <= '0;
			idx_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) fe_q <= frame_end;
			if (cfg_wr_en) thr_q <= cfg_wr_data;
			v_s1 <= cmd.walk_issue;
			v_s2 <= v_s1;
			if (cmd.load_mean) idx_q <= '0;
			else if (cmd.walk_issue) idx_q <= idx_q + 1'b1;
			if (cmd.start_mean) acc_q <= '0;
			else if (v_s2) acc_q <= acc_q + hscd_pkg::ACC_W'(term_s2);
			if (cmd.emit) begin
				hue_total_q <= '0;
				count_q     <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (cmd.commit) begin
					hue_total_q <= hue_total_q + hscd_pkg::TOT_W'(hue_val);
					count_q     <= count_q + 1'b1;
				end
				if (out_xfer) out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.grey      = (dlt == '0);
		status.full      = (count_q == hscd_pkg::CNT_W'(hscd_pkg::MAX_PIXELS));
		status.frame_end = fe_q;
		status.div_done  = div_done;
		status.walk_last = (idx_q == count_q - 1'b1);
		status.pipe_busy = v_s1 | v_s2;
		status.out_free  = ~out_valid_q | out_ready;
	end

	assign out_valid    = out_valid_q;
	assign hue_spread   = spread_q;
	assign cast_present = cast_q;
	assign pixel_total  = total_q;

	`HSCD_NEVER(a_commit_full, cmd.commit && status.full, "hue committed into a full store")
	`HSCD_NEVER(a_cnt_range, count_q > hscd_pkg::CNT_W'(hscd_pkg::MAX_PIXELS), "pixel count overran the store")
	`HSCD_NEVER(a_emit_busy, cmd.emit && (v_s1 || v_s2), "result emitted while walk still in flight")
	`HSCD_ASSERT(a_out_hold, out_valid_q && !out_ready |=> out_valid_q, "pending result dropped")

endmodule

FILE: rtl/core/hscd_ctrl.sv
// ----------------------------------------------------------------------------
// hscd_ctrl
// Sequencer: per-pixel hue divide (skipped for grey pixels) and commit, then
// the end-of-frame mean, deviation walk, spread divide and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hscd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hscd_pkg::status_t status,
	output hscd_pkg::cmd_t    cmd
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PREP   = 9'b000000010,
		S_HUE    = 9'b000000100,
		S_MGO    = 9'b000001000,
		S_MEAN   = 9'b000010000,
		S_WALK   = 9'b000100000,
		S_DRAIN  = 9'b001000000,
		S_SPREAD = 9'b010000000,
		S_EMIT   = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	logic   div_launch;
	logic   div_running;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_PREP;
				end
			end
			S_PREP: begin
				if (status.full) begin
					state_d = status.frame_end ? S_MGO : S_IDLE;
				end else if (status.grey) begin
					cmd.commit   = 1'b1;
					cmd.hue_zero = 1'b1;
					state_d      = status.frame_end ? S_MGO : S_IDLE;
				end else begin
					cmd.start_hue = 1'b1;
					state_d       = S_HUE;
				end
			end
			S_HUE: begin
				if (status.div_done) begin
					cmd.commit = 1'b1;
					state_d    = status.frame_end ? S_MGO : S_IDLE;
				end
			end
			S_MGO: begin
				cmd.start_mean = 1'b1;
				state_d        = S_MEAN;
			end
			S_MEAN: begin
				if (status.div_done) begin
					cmd.load_mean = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_issue = 1'b1;
				if (status.walk_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!status.pipe_busy) begin
					cmd.start_spread = 1'b1;
					state_d          = S_SPREAD;
				end
			end
			S_SPREAD: begin
				if (status.div_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign div_launch  = cmd.start_hue | cmd.start_mean | cmd.start_spread;
	assign div_running = (state_q == S_HUE) | (state_q == S_MEAN) | (state_q == S_SPREAD);

	`HSCD_ASSERT(a_onehot, $onehot(state_q), "controller state not one-hot")
	`HSCD_ASSERT(a_load_prep, cmd.load |=> state_q == S_PREP, "accepted pixel not prepared")
	`HSCD_NEVER(a_div_overlap, div_launch && div_running, "divide launched while busy")

endmodule

FILE: rtl/core/hue_spread_color_cast_detect_top.sv
// ----------------------------------------------------------------------------
// hue_spread_color_cast_detect_top
// Frame hue spread measurement and color cast flag.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one RGB pixel per transfer, frame_end
// high on the last pixel of a frame. Output channel (out_valid/out_ready):
// one result per frame: hue_spread (Q0.32), cast_present, pixel_total.
// Config: cfg_wr_en/cfg_wr_data write spread_threshold; write only when idle.
// A grey pixel skips the divide; any other pixel waits for the shared
// one-bit-per-cycle 48-bit divider computing the hue, and no new pixel is
// taken until the last one is committed. On frame_end the block runs the
// mean divide, walks the N stored hues (one store read per cycle), drains
// the squaring pipeline, runs the spread divide and raises out_valid.
// Pixels past 65536 in a frame are dropped; frame_end still closes it.
// Reset clears the counters, sums and pending result and loads the default
// threshold; the hue store needs no clearing pass.
// If the receiver stalls, the result register holds and the next frame's
// pixels keep flowing; only the following result waits for it to drain.
// ----------------------------------------------------------------------------
module hue_spread_color_cast_detect_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [hscd_pkg::LVL_W-1:0] red_level,
	input  logic [hscd_pkg::LVL_W-1:0] green_level,
	input  logic [hscd_pkg::LVL_W-1:0] blue_level,
	input  logic                       frame_end,
	input  logic                       cfg_wr_en,
	input  logic [hscd_pkg::THR_W-1:0] cfg_wr_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [hscd_pkg::THR_W-1:0] hue_spread,
	output logic                       cast_present,
	output logic [hscd_pkg::CNT_W-1:0] pixel_total
);

	hscd_pkg::cmd_t    cmd;
	hscd_pkg::status_t status;

	hscd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	hscd_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.frame_end    (frame_end),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hue_spread   (hue_spread),
		.cast_present (cast_present),
		.pixel_total  (pixel_total)
	);

endmodule
